[src/lrp_pkg.sv]
// Package with the item types and codes of the shift-reduce parse engine.
`default_nettype none
package lrp_pkg;
   localparam logic [2:0] KIND_TOKEN   = 3'd0;
   localparam logic [2:0] KIND_ACTION  = 3'd1;
   localparam logic [2:0] KIND_GOTO    = 3'd2;
   localparam logic [2:0] KIND_RULE    = 3'd3;
   localparam logic [2:0] KIND_RESTART = 3'd4;

   localparam logic [1:0] ACT_EMPTY  = 2'd0;
   localparam logic [1:0] ACT_SHIFT  = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_ACCEPT = 2'd3;

   localparam logic [2:0] EV_REDUCE   = 3'd0;
   localparam logic [2:0] EV_SHIFT    = 3'd1;
   localparam logic [2:0] EV_ACCEPT   = 3'd2;
   localparam logic [2:0] EV_NOENTRY  = 3'd3;
   localparam logic [2:0] EV_OVERFLOW = 3'd4;
   localparam logic [2:0] EV_TOOMANY  = 3'd5;
   localparam logic [2:0] EV_IGNORED  = 3'd6;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] state_index;
      logic [4:0] symbol;
      logic [1:0] entry_type;
      logic [5:0] entry_value;
      logic [5:0] rule_number;
      logic [3:0] rule_length;
      logic [3:0] rule_lhs;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [5:0] reduced_rule;
      logic [5:0] new_top_state;
      logic       last;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;
      logic do_write;
      logic do_restart;
      logic rd_top;
      logic rd_action;
      logic rd_rule;
      logic pop;
      logic push_shift;
      logic push_goto;
      logic clr_count;
      logic set_over;
      logic emit;
      logic [2:0] ev;
      logic emit_rule;
      logic emit_last;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic       is_token;
      logic       is_write;
      logic       is_restart;
      logic       over;
      logic [1:0] atype;
      logic       stack_full;
      logic       count_limit;
      logic       rule_bad;
      logic       len_bad;
      logic       goto_valid;
      logic       rsp_busy;
   } sts_type;
endpackage
`default_nettype wire

[src/lrp_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[src/lrp_datapath.sv]
// Datapath of the parse engine: tables, state stack, counters and result register.
`default_nettype none
module lrp_datapath #(
   parameter int NUM_STATES       = 64,
   parameter int NUM_TERMINALS    = 32,
   parameter int NUM_NONTERMINALS = 16,
   parameter int NUM_RULES        = 64,
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_REDUCTIONS   = 63
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lrp_pkg::req_type req_data,
   input  wire lrp_pkg::cmd_type cmd,
   output lrp_pkg::sts_type      sts,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output lrp_pkg::rsp_type      rsp_data
);
   localparam int RW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int DW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam int AD = NUM_STATES * NUM_TERMINALS;
   localparam int GD = NUM_STATES * NUM_NONTERMINALS;
   localparam int AW = $clog2(AD);
   localparam int GW = $clog2(GD);
   localparam int CLRN = (AD > GD) ? ((AD > NUM_RULES) ? AD : NUM_RULES)
                                   : ((GD > NUM_RULES) ? GD : NUM_RULES);
   localparam int CW = $clog2(CLRN + 1);

   lrp_pkg::req_type req_ff;
   logic [PW-1:0] sp_ff;
   logic          over_ff;
   logic [5:0]    cnt_ff;
   logic [5:0]    top_ff;
   logic [5:0]    aval_ff;
   logic [CW-1:0] clr_ff;
   logic          clearing;
   logic          rsp_valid_ff;
   lrp_pkg::rsp_type rsp_ff;

   logic [7:0] act_rd;
   logic [6:0] goto_rd;
   logic [7:0] rule_rd;
   logic [5:0] stk_rd;

   logic          act_we, goto_we, rule_we, stk_we;
   logic [AW-1:0] act_wa, act_ra;
   logic [GW-1:0] goto_wa, goto_ra;
   logic [RW-1:0] rule_wa, rule_ra;
   logic [DW-1:0] stk_wa, stk_ra;
   logic [7:0]    act_wd;
   logic [6:0]    goto_wd;
   logic [7:0]    rule_wd;
   logic [5:0]    stk_wd;
   logic          act_ok, goto_ok;
   logic [PW-1:0] sp_pop;
   logic [3:0]    rlen;
   logic [3:0]    rlhs;
   logic [1:0]    atype;

   assign clearing = (clr_ff != CW'(CLRN));
   assign rlen = rule_rd[7:4];
   assign rlhs = rule_rd[3:0];
   assign sp_pop = sp_ff - PW'(rlen);
   assign act_ok = (32'(top_ff) < NUM_STATES) && (32'(req_ff.symbol) < NUM_TERMINALS);
   assign goto_ok = (32'(stk_rd) < NUM_STATES) && (32'(rlhs) < NUM_NONTERMINALS);
   assign atype = act_ok ? act_rd[7:6] : lrp_pkg::ACT_EMPTY;

   always_comb begin
      act_we  = 1'b0;
      goto_we = 1'b0;
      rule_we = 1'b0;
      act_wa  = AW'(32'(req_ff.state_index) * NUM_TERMINALS + 32'(req_ff.symbol));
      goto_wa = GW'(32'(req_ff.state_index) * NUM_NONTERMINALS + 32'(req_ff.symbol));
      rule_wa = RW'(req_ff.rule_number);
      act_wd  = {req_ff.entry_type, req_ff.entry_value};
      goto_wd = (req_ff.entry_type != 2'd0) ? {1'b1, req_ff.entry_value} : 7'd0;
      rule_wd = {req_ff.rule_length, req_ff.rule_lhs};
      if (clearing) begin
         act_we  = 32'(clr_ff) < AD;
         goto_we = 32'(clr_ff) < GD;
         rule_we = 32'(clr_ff) < NUM_RULES;
         act_wa  = AW'(clr_ff);
         goto_wa = GW'(clr_ff);
         rule_wa = RW'(clr_ff);
         act_wd  = 8'd0;
         goto_wd = 7'd0;
         rule_wd = 8'd0;
      end else if (cmd.do_write) begin
         unique case (req_ff.kind)
            lrp_pkg::KIND_ACTION: act_we = (32'(req_ff.state_index) < NUM_STATES)
                                         && (32'(req_ff.symbol) < NUM_TERMINALS);
            lrp_pkg::KIND_GOTO:   goto_we = (32'(req_ff.state_index) < NUM_STATES)
                                          && (32'(req_ff.symbol) < NUM_NONTERMINALS);
            lrp_pkg::KIND_RULE:   rule_we = 32'(req_ff.rule_number) < NUM_RULES;
            default: ;
         endcase
      end
   end

   assign act_ra  = AW'(32'(top_ff) * NUM_TERMINALS + 32'(req_ff.symbol));
   assign goto_ra = GW'(32'(stk_rd) * NUM_NONTERMINALS + 32'(rlhs));
   assign rule_ra = RW'(act_rd[5:0]);

   // Stack read: top entry, or entry uncovered by the pop.
   assign stk_ra = cmd.pop ? DW'(sp_pop - PW'(1)) : DW'(sp_ff - PW'(1));
   assign stk_we = cmd.push_shift || cmd.push_goto || cmd.do_restart || clearing;
   assign stk_wa = (cmd.do_restart || clearing) ? DW'(0) : DW'(sp_ff);
   assign stk_wd = cmd.push_shift ? aval_ff : (cmd.push_goto ? goto_rd[5:0] : 6'd0);

   lrp_ram #(.WIDTH(8), .DEPTH(AD)) u_action (
      .clock, .wr_en(act_we), .wr_addr(act_wa), .wr_data(act_wd),
      .rd_addr(act_ra), .rd_data(act_rd));
   lrp_ram #(.WIDTH(7), .DEPTH(GD)) u_goto (
      .clock, .wr_en(goto_we), .wr_addr(goto_wa), .wr_data(goto_wd),
      .rd_addr(goto_ra), .rd_data(goto_rd));
   lrp_ram #(.WIDTH(8), .DEPTH(NUM_RULES)) u_rule (
      .clock, .wr_en(rule_we), .wr_addr(rule_wa), .wr_data(rule_wd),
      .rd_addr(rule_ra), .rd_data(rule_rd));
   lrp_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= PW'(1);
         over_ff      <= 1'b0;
         cnt_ff       <= 6'd0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= 6'd0;
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + CW'(1);
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.do_restart) begin
            sp_ff   <= PW'(1);
            over_ff <= 1'b0;
         end
         if (cmd.rd_top) begin
            top_ff <= stk_rd;
         end
         if (cmd.push_shift) begin
            sp_ff <= sp_ff + PW'(1);
         end
         if (cmd.pop) begin
            sp_ff <= sp_pop;
         end
         if (cmd.push_goto) begin
            sp_ff  <= sp_ff + PW'(1);
            top_ff <= goto_rd[5:0];
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (cmd.clr_count) begin
            cnt_ff <= 6'd0;
         end
         if (cmd.set_over) begin
            over_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.rd_action) begin
         aval_ff <= act_rd[5:0];
      end
      if (cmd.emit) begin
         rsp_ff.event_res    <= cmd.ev;
         rsp_ff.reduced_rule <= cmd.emit_rule ? aval_ff : 6'd0;
         rsp_ff.new_top_state <= cmd.push_shift ? aval_ff
                               : (cmd.push_goto ? goto_rd[5:0] : top_ff);
         rsp_ff.last         <= cmd.emit_last;
      end
   end

   always_comb begin
      sts.is_token    = (req_ff.kind == lrp_pkg::KIND_TOKEN) && !clearing;
      sts.is_write    = (req_ff.kind == lrp_pkg::KIND_ACTION)
                     || (req_ff.kind == lrp_pkg::KIND_GOTO)
                     || (req_ff.kind == lrp_pkg::KIND_RULE);
      sts.is_restart  = req_ff.kind == lrp_pkg::KIND_RESTART;
      sts.over        = over_ff;
      sts.atype       = atype;
      sts.stack_full  = 32'(sp_ff) >= STACK_DEPTH;
      sts.count_limit = 32'(cnt_ff) >= MAX_REDUCTIONS;
      sts.rule_bad    = 32'(aval_ff) >= NUM_RULES;
      sts.len_bad     = PW'(rlen) >= sp_ff || 32'(rlen) >= STACK_DEPTH + 1;
      sts.goto_valid  = goto_ok && goto_rd[6];
      sts.rsp_busy    = rsp_valid_ff || clearing;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

[src/lrp_control.sv]
// Controller state machine of the parse engine.
`default_nettype none
module lrp_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output lrp_pkg::cmd_type      cmd,
   input  wire lrp_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_TOP, ST_ACTION, ST_RULE, ST_POP, ST_GOTO, ST_WAIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !sts.rsp_busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.clr_count = 1'b1;
            if (sts.is_write) begin
               cmd.do_write = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.is_restart) begin
               cmd.do_restart = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.is_token) begin
               if (sts.over) begin
                  cmd.emit = 1'b1;
                  cmd.ev = lrp_pkg::EV_IGNORED;
                  cmd.emit_last = 1'b1;
                  state_in = ST_WAIT;
               end else begin
                  cmd.rd_top = 1'b1;
                  state_in = ST_TOP;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TOP: begin
            // The top state is registered; the action read runs this cycle.
            state_in = ST_ACTION;
         end
         ST_ACTION: begin
            cmd.rd_action = 1'b1;
            if (sts.rsp_busy) begin
               state_in = ST_ACTION;
            end else begin
               unique case (sts.atype)
                  lrp_pkg::ACT_EMPTY: begin
                     cmd.emit = 1'b1;
                     cmd.ev = lrp_pkg::EV_NOENTRY;
                     cmd.emit_last = 1'b1;
                     cmd.set_over = 1'b1;
                     state_in = ST_WAIT;
                  end
                  lrp_pkg::ACT_ACCEPT: begin
                     cmd.emit = 1'b1;
                     cmd.ev = lrp_pkg::EV_ACCEPT;
                     cmd.emit_last = 1'b1;
                     cmd.set_over = 1'b1;
                     state_in = ST_WAIT;
                  end
                  lrp_pkg::ACT_SHIFT: begin
                     state_in = ST_RULE;
                  end
                  default: begin
                     state_in = ST_RULE;
                  end
               endcase
            end
         end
         ST_RULE: begin
            // Shift action or reduce with rule entry now read.
            if (sts.atype == lrp_pkg::ACT_SHIFT) begin
               cmd.emit = 1'b1;
               cmd.emit_last = 1'b1;
               if (sts.stack_full) begin
                  cmd.ev = lrp_pkg::EV_OVERFLOW;
                  cmd.set_over = 1'b1;
               end else begin
                  cmd.ev = lrp_pkg::EV_SHIFT;
                  cmd.push_shift = 1'b1;
               end
               state_in = ST_WAIT;
            end else if (sts.count_limit || sts.rule_bad || sts.len_bad) begin
               cmd.emit = 1'b1;
               cmd.ev = sts.count_limit ? lrp_pkg::EV_TOOMANY : lrp_pkg::EV_NOENTRY;
               cmd.emit_last = 1'b1;
               cmd.set_over = 1'b1;
               state_in = ST_WAIT;
            end else begin
               cmd.pop = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            // The uncovered top state is read; the goto read runs this cycle.
            cmd.rd_top = 1'b1;
            state_in = ST_GOTO;
         end
         ST_GOTO: begin
            if (sts.rsp_busy) begin
               state_in = ST_GOTO;
            end else if (!sts.goto_valid) begin
               cmd.emit = 1'b1;
               cmd.ev = lrp_pkg::EV_NOENTRY;
               cmd.emit_last = 1'b1;
               cmd.set_over = 1'b1;
               state_in = ST_WAIT;
            end else if (sts.stack_full) begin
               cmd.emit = 1'b1;
               cmd.ev = lrp_pkg::EV_OVERFLOW;
               cmd.emit_last = 1'b1;
               cmd.set_over = 1'b1;
               state_in = ST_WAIT;
            end else begin
               cmd.emit = 1'b1;
               cmd.ev = lrp_pkg::EV_REDUCE;
               cmd.emit_rule = 1'b1;
               cmd.push_goto = 1'b1;
               state_in = ST_TOP;
            end
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

[src/lr_shift_reduce_parse_engine.sv]
// Top level of the table-driven LR shift-reduce parse engine.
// A write or restart item passes through the decode state only. A token reaches an accept
// or no-entry result at the first lookup in the action state and a shift in the rule state,
// and each reduction runs through the rule, pop and goto states, set by the chain of
// registered reads through the stack, action, rule and goto memories. A result register
// holds each result until it is taken, and the engine waits for it to be taken before the
// next action lookup or the next item. After reset the engine clears every table entry
// (the largest table has 2048 entries by default) before it takes an item.
`default_nettype none
module lr_shift_reduce_parse_engine #(
   parameter int NUM_STATES       = 64,
   parameter int NUM_TERMINALS    = 32,
   parameter int NUM_NONTERMINALS = 16,
   parameter int NUM_RULES        = 64,
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_REDUCTIONS   = 63
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lrp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lrp_pkg::rsp_type      rsp_data
);
   lrp_pkg::cmd_type cmd;
   lrp_pkg::sts_type sts;

   lrp_control u_control (
      .clock, .reset, .req_valid, .req_ready, .cmd, .sts);

   lrp_datapath #(
      .NUM_STATES(NUM_STATES), .NUM_TERMINALS(NUM_TERMINALS),
      .NUM_NONTERMINALS(NUM_NONTERMINALS), .NUM_RULES(NUM_RULES),
      .STACK_DEPTH(STACK_DEPTH), .MAX_REDUCTIONS(MAX_REDUCTIONS)
   ) u_datapath (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_ready, .rsp_valid, .rsp_data);
endmodule
`default_nettype wire
